// File: hw/rtl/srsw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsw_pkg: shared types and constants
// Command and result codes, register indexes, the sequencer state type and
// the configuration bundle of the selective-repeat send window.
// ----------------------------------------------------------------------------
package srsw_pkg;

    localparam int WINDOW_DEPTH_DEF = 32;
    localparam int AGE_WIDTH_DEF    = 16;

    localparam int SEQ_W   = 32;
    localparam int LIM_W   = 6;
    localparam int RTO_W   = 16;
    localparam int PROT_W  = 32;
    localparam int TYPE_W  = 8;
    localparam int CMD_W   = 2;
    localparam int KIND_W  = 3;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ROUND = 2'd2;

    localparam logic [CIDX_W-1:0] REG_TOTAL    = 3'd0;
    localparam logic [CIDX_W-1:0] REG_WINDOW   = 3'd1;
    localparam logic [CIDX_W-1:0] REG_BATCH    = 3'd2;
    localparam logic [CIDX_W-1:0] REG_RTO      = 3'd3;
    localparam logic [CIDX_W-1:0] REG_PROTOCOL = 3'd4;
    localparam logic [CIDX_W-1:0] REG_ACK_TYPE = 3'd5;

    typedef enum logic [KIND_W-1:0] {
        KIND_NEW     = 3'd0,
        KIND_RETX    = 3'd1,
        KIND_ACKED   = 3'd2,
        KIND_IGNORED = 3'd3,
        KIND_IDLE    = 3'd4,
        KIND_DONE    = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK_RD,
        ST_TICK_WR,
        ST_ACK_RD,
        ST_ACK_CMP,
        ST_SEND,
        ST_RETX_RD,
        ST_RETX_CMP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [SEQ_W-1:0]  packet_total;
        logic [LIM_W-1:0]  window_limit;
        logic [LIM_W-1:0]  send_batch;
        logic [RTO_W-1:0]  rto_ticks;
        logic [PROT_W-1:0] proto_ident;
        logic [TYPE_W-1:0] ack_type_code;
    } cfg_t;

endpackage

// File: hw/rtl/selective_repeat_send_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_send_window: sender window of a selective-repeat ARQ
// Keeps the outstanding sequence numbers and their ages in a slot table,
// ages them on ticks, frees them on acknowledgments and issues new sends and
// retransmits on send rounds.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Ports                                     Accepted when
//  request   in         s_cmd, s_ack_seq, s_ack_protocol, s_ack_type  s_valid & s_ready
//  result    out        m_kind, m_seq, m_last                     m_valid & m_ready
//  config    in         cfg_index, cfg_wdata                      cfg_wr_en
//
// One request is handled at a time; the next one is accepted only after the
// current one has finished. A tick or an acknowledgment walks the slot table,
// skipping free slots and reading each occupied slot from memory before it is
// updated or compared; an acknowledgment stops at the first matching slot.
// A round first issues its new sends, then walks the table for retransmits.
// Every result leaves through a one-deep hold stage and an output register;
// a stalled result channel pauses the walk.
// Reset is synchronous and clears the control state and the slot valid bits;
// the sequence and age memories need no clearing pass.
//
module selective_repeat_send_window #(
    parameter int WINDOW_DEPTH = srsw_pkg::WINDOW_DEPTH_DEF,
    parameter int AGE_WIDTH    = srsw_pkg::AGE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [srsw_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [srsw_pkg::CDATA_W-1:0]  cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [srsw_pkg::CMD_W-1:0]    s_cmd,
    input  logic [srsw_pkg::SEQ_W-1:0]    s_ack_seq,
    input  logic [srsw_pkg::PROT_W-1:0]   s_ack_protocol,
    input  logic [srsw_pkg::TYPE_W-1:0]   s_ack_type,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [srsw_pkg::KIND_W-1:0]   m_kind,
    output logic [srsw_pkg::SEQ_W-1:0]    m_seq,
    output logic                          m_last
);

    localparam int IDXW = WINDOW_DEPTH > 1 ? $clog2(WINDOW_DEPTH) : 1;

    srsw_pkg::cfg_t               cfg;
    logic                         mem_re, seq_we, age_we;
    logic [IDXW-1:0]              mem_raddr, mem_waddr;
    logic [srsw_pkg::SEQ_W-1:0]   seq_wdata, seq_rdata;
    logic [AGE_WIDTH-1:0]         age_wdata, age_rdata;

    // Control registers; the user must write them only while the block is idle, the block itself does not enforce this.
    srsw_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Sequencer: owns the valid bits and counters, drives both memories.
    srsw_ctrl #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .AGE_WIDTH    (AGE_WIDTH)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_ack_seq      (s_ack_seq),
        .s_ack_protocol (s_ack_protocol),
        .s_ack_type     (s_ack_type),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_seq          (m_seq),
        .m_last         (m_last),
        .mem_re         (mem_re),
        .mem_raddr      (mem_raddr),
        .seq_we         (seq_we),
        .age_we         (age_we),
        .mem_waddr      (mem_waddr),
        .seq_wdata      (seq_wdata),
        .age_wdata      (age_wdata),
        .seq_rdata      (seq_rdata),
        .age_rdata      (age_rdata)
    );

    // Sequence number of each slot.
    srsw_ram #(
        .WIDTH (srsw_pkg::SEQ_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_seq_ram (
        .aclk  (aclk),
        .we    (seq_we),
        .waddr (mem_waddr),
        .wdata (seq_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (seq_rdata)
    );

    // Age of each slot in ticks, saturating.
    srsw_ram #(
        .WIDTH (AGE_WIDTH),
        .DEPTH (WINDOW_DEPTH)
    ) u_age_ram (
        .aclk  (aclk),
        .we    (age_we),
        .waddr (mem_waddr),
        .wdata (age_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (age_rdata)
    );

endmodule

// File: hw/rtl/srsw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsw_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module srsw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/srsw_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsw_cfg: configuration register file
// Decodes the write port into the six control registers.
// ----------------------------------------------------------------------------
module srsw_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [srsw_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [srsw_pkg::CDATA_W-1:0]  cfg_wdata,
    output srsw_pkg::cfg_t                cfg
);

    srsw_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.packet_total  <= '0;
            cfg_reg.window_limit  <= srsw_pkg::LIM_W'(32);
            cfg_reg.send_batch    <= srsw_pkg::LIM_W'(32);
            cfg_reg.rto_ticks     <= srsw_pkg::RTO_W'(100);
            cfg_reg.proto_ident   <= '0;
            cfg_reg.ack_type_code <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                srsw_pkg::REG_TOTAL:    cfg_reg.packet_total <= cfg_wdata;
                srsw_pkg::REG_WINDOW:
                    cfg_reg.window_limit <= cfg_wdata[srsw_pkg::LIM_W-1:0];
                srsw_pkg::REG_BATCH:
                    cfg_reg.send_batch <= cfg_wdata[srsw_pkg::LIM_W-1:0];
                srsw_pkg::REG_RTO:
                    cfg_reg.rto_ticks <= cfg_wdata[srsw_pkg::RTO_W-1:0];
                srsw_pkg::REG_PROTOCOL: cfg_reg.proto_ident <= cfg_wdata;
                srsw_pkg::REG_ACK_TYPE:
                    cfg_reg.ack_type_code <= cfg_wdata[srsw_pkg::TYPE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/srsw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsw_ctrl: window sequencer
// Walks the slot table in memory for ticks, acknowledgments and send rounds,
// and delivers results through a one-deep hold stage and an output register.
// ----------------------------------------------------------------------------
module srsw_ctrl #(
    parameter int WINDOW_DEPTH = srsw_pkg::WINDOW_DEPTH_DEF,
    parameter int AGE_WIDTH    = srsw_pkg::AGE_WIDTH_DEF,
    localparam int IDXW        = WINDOW_DEPTH > 1 ? $clog2(WINDOW_DEPTH) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  srsw_pkg::cfg_t                cfg,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [srsw_pkg::CMD_W-1:0]    s_cmd,
    input  logic [srsw_pkg::SEQ_W-1:0]    s_ack_seq,
    input  logic [srsw_pkg::PROT_W-1:0]   s_ack_protocol,
    input  logic [srsw_pkg::TYPE_W-1:0]   s_ack_type,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [srsw_pkg::KIND_W-1:0]   m_kind,
    output logic [srsw_pkg::SEQ_W-1:0]    m_seq,
    output logic                          m_last,
    output logic                          mem_re,
    output logic [IDXW-1:0]               mem_raddr,
    output logic                          seq_we,
    output logic                          age_we,
    output logic [IDXW-1:0]               mem_waddr,
    output logic [srsw_pkg::SEQ_W-1:0]    seq_wdata,
    output logic [AGE_WIDTH-1:0]          age_wdata,
    input  logic [srsw_pkg::SEQ_W-1:0]    seq_rdata,
    input  logic [AGE_WIDTH-1:0]          age_rdata
);

    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int CMP_W  = AGE_WIDTH > srsw_pkg::RTO_W ? AGE_WIDTH : srsw_pkg::RTO_W;
    localparam logic [IDXW-1:0] IDX_LAST = IDXW'(WINDOW_DEPTH - 1);

    srsw_pkg::state_t state_reg, state_next;

    logic [IDXW-1:0]              idx_reg, idx_next;
    logic [srsw_pkg::CMD_W-1:0]   cmd_reg, cmd_next;
    logic [srsw_pkg::SEQ_W-1:0]   ack_seq_reg, ack_seq_next;
    logic                         removed_reg, removed_next;
    logic [srsw_pkg::SEQ_W-1:0]   nseq_reg, nseq_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [srsw_pkg::LIM_W-1:0]   sent_reg, sent_next;
    logic [WINDOW_DEPTH-1:0]      valid_reg, valid_next;
    logic                         hold_valid_reg, hold_valid_next;
    srsw_pkg::kind_t              hold_kind_reg, hold_kind_next;
    logic [srsw_pkg::SEQ_W-1:0]   hold_seq_reg, hold_seq_next;
    logic                         out_valid_reg, out_valid_next;
    srsw_pkg::kind_t              out_kind_reg, out_kind_next;
    logic [srsw_pkg::SEQ_W-1:0]   out_seq_reg, out_seq_next;
    logic                         out_last_reg, out_last_next;

    logic                         out_free, emit_ok, idx_last, slot_live;
    logic                         free_found, send_go, retx_hit, ack_ok;
    logic [IDXW-1:0]              free_idx;
    logic [srsw_pkg::LIM_W-1:0]   cap;
    logic                         emit_new;
    srsw_pkg::kind_t              emit_kind;
    logic [srsw_pkg::SEQ_W-1:0]   emit_seq;
    srsw_pkg::kind_t              final_kind;
    logic [srsw_pkg::SEQ_W-1:0]   final_seq;

    assign out_free  = !out_valid_reg || m_ready;
    assign emit_ok   = !hold_valid_reg || out_free;
    assign idx_last  = idx_reg == IDX_LAST;
    assign slot_live = valid_reg[idx_reg];
    assign ack_ok    = s_ack_protocol == cfg.proto_ident && s_ack_type == cfg.ack_type_code;
    assign cap       = cfg.send_batch < srsw_pkg::LIM_W'(WINDOW_DEPTH)
                       ? cfg.send_batch : srsw_pkg::LIM_W'(WINDOW_DEPTH);
    assign retx_hit  = CMP_W'(age_rdata) >= CMP_W'(cfg.rto_ticks);

    // Lowest free slot.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = WINDOW_DEPTH - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IDXW'(i);
            end
        end
    end

    assign send_go = nseq_reg < cfg.packet_total && sent_reg < cap
                     && srsw_pkg::LIM_W'(count_reg) < cfg.window_limit && free_found;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            srsw_pkg::ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_cmd)
                        srsw_pkg::CMD_TICK:  state_next = srsw_pkg::ST_TICK_RD;
                        srsw_pkg::CMD_ACK:
                            state_next = ack_ok ? srsw_pkg::ST_ACK_RD : srsw_pkg::ST_FINISH;
                        srsw_pkg::CMD_ROUND: state_next = srsw_pkg::ST_SEND;
                        default:             state_next = srsw_pkg::ST_FINISH;
                    endcase
                end
            end
            srsw_pkg::ST_TICK_RD: begin
                if (slot_live)     state_next = srsw_pkg::ST_TICK_WR;
                else if (idx_last) state_next = srsw_pkg::ST_FINISH;
            end
            srsw_pkg::ST_TICK_WR: begin
                state_next = idx_last ? srsw_pkg::ST_FINISH : srsw_pkg::ST_TICK_RD;
            end
            srsw_pkg::ST_ACK_RD: begin
                if (slot_live)     state_next = srsw_pkg::ST_ACK_CMP;
                else if (idx_last) state_next = srsw_pkg::ST_FINISH;
            end
            srsw_pkg::ST_ACK_CMP: begin
                if (seq_rdata == ack_seq_reg || idx_last) state_next = srsw_pkg::ST_FINISH;
                else                                     state_next = srsw_pkg::ST_ACK_RD;
            end
            srsw_pkg::ST_SEND: begin
                if (!send_go) state_next = srsw_pkg::ST_RETX_RD;
            end
            srsw_pkg::ST_RETX_RD: begin
                if (slot_live)     state_next = srsw_pkg::ST_RETX_CMP;
                else if (idx_last) state_next = srsw_pkg::ST_FINISH;
            end
            srsw_pkg::ST_RETX_CMP: begin
                if (!retx_hit || emit_ok) begin
                    state_next = idx_last ? srsw_pkg::ST_FINISH : srsw_pkg::ST_RETX_RD;
                end
            end
            srsw_pkg::ST_FINISH: begin
                if (out_free) state_next = srsw_pkg::ST_IDLE;
            end
            default: state_next = srsw_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        idx_next     = idx_reg;
        cmd_next     = cmd_reg;
        ack_seq_next = ack_seq_reg;
        removed_next = removed_reg;
        nseq_next    = nseq_reg;
        count_next   = count_reg;
        sent_next    = sent_reg;
        valid_next   = valid_reg;
        mem_re       = 1'b0;
        mem_raddr    = idx_reg;
        seq_we       = 1'b0;
        age_we       = 1'b0;
        mem_waddr    = idx_reg;
        seq_wdata    = nseq_reg;
        age_wdata    = '0;
        emit_new     = 1'b0;
        emit_kind    = srsw_pkg::KIND_NEW;
        emit_seq     = nseq_reg;
        s_ready      = 1'b0;

        unique case (state_reg)
            srsw_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    idx_next     = '0;
                    cmd_next     = s_cmd;
                    ack_seq_next = s_ack_seq;
                    removed_next = 1'b0;
                    sent_next    = '0;
                end
            end
            srsw_pkg::ST_TICK_RD, srsw_pkg::ST_ACK_RD, srsw_pkg::ST_RETX_RD: begin
                mem_re = slot_live;
                if (!slot_live && !idx_last) idx_next = idx_reg + 1'b1;
            end
            srsw_pkg::ST_TICK_WR: begin
                age_we    = age_rdata != {AGE_WIDTH{1'b1}};
                age_wdata = AGE_WIDTH'(age_rdata + 1'b1);
                if (!idx_last) idx_next = idx_reg + 1'b1;
            end
            srsw_pkg::ST_ACK_CMP: begin
                if (seq_rdata == ack_seq_reg) begin
                    valid_next[idx_reg] = 1'b0;
                    count_next          = count_reg - 1'b1;
                    removed_next        = 1'b1;
                end else if (!idx_last) begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            srsw_pkg::ST_SEND: begin
                if (!send_go) begin
                    idx_next = '0;
                end else if (emit_ok) begin
                    seq_we               = 1'b1;
                    age_we               = 1'b1;
                    mem_waddr            = free_idx;
                    valid_next[free_idx] = 1'b1;
                    count_next           = count_reg + 1'b1;
                    nseq_next            = nseq_reg + 1'b1;
                    sent_next            = sent_reg + 1'b1;
                    emit_new             = 1'b1;
                end
            end
            srsw_pkg::ST_RETX_CMP: begin
                if (!retx_hit || emit_ok) begin
                    if (!idx_last) idx_next = idx_reg + 1'b1;
                end
                if (retx_hit && emit_ok) begin
                    age_we    = 1'b1;
                    emit_new  = 1'b1;
                    emit_kind = srsw_pkg::KIND_RETX;
                    emit_seq  = seq_rdata;
                end
            end
            srsw_pkg::ST_FINISH: ;
            default: ;
        endcase
    end

    // Result of the final step when no earlier result is held.
    always_comb begin
        final_kind = srsw_pkg::KIND_IDLE;
        final_seq  = '0;
        case (cmd_reg)
            srsw_pkg::CMD_ACK: begin
                final_kind = removed_reg ? srsw_pkg::KIND_ACKED : srsw_pkg::KIND_IGNORED;
                final_seq  = ack_seq_reg;
            end
            srsw_pkg::CMD_ROUND: begin
                if (nseq_reg >= cfg.packet_total && count_reg == '0) begin
                    final_kind = srsw_pkg::KIND_DONE;
                    final_seq  = nseq_reg;
                end
            end
            default: ;
        endcase
    end

    // Hold stage and output register. A result waits in the hold stage until
    // the next one arrives or the item finishes, which decides its last flag.
    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_kind_next  = hold_kind_reg;
        hold_seq_next   = hold_seq_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_kind_next   = out_kind_reg;
        out_seq_next    = out_seq_reg;
        out_last_next   = out_last_reg;
        if (emit_new) begin
            if (hold_valid_reg) begin
                out_valid_next = 1'b1;
                out_kind_next  = hold_kind_reg;
                out_seq_next   = hold_seq_reg;
                out_last_next  = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_kind_next  = emit_kind;
            hold_seq_next   = emit_seq;
        end else if (state_reg == srsw_pkg::ST_FINISH && out_free) begin
            out_valid_next  = 1'b1;
            out_last_next   = 1'b1;
            out_kind_next   = hold_valid_reg ? hold_kind_reg : final_kind;
            out_seq_next    = hold_valid_reg ? hold_seq_reg : final_seq;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= srsw_pkg::ST_IDLE;
            nseq_reg       <= '0;
            count_reg      <= '0;
            valid_reg      <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            nseq_reg       <= nseq_next;
            count_reg      <= count_next;
            valid_reg      <= valid_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        cmd_reg       <= cmd_next;
        ack_seq_reg   <= ack_seq_next;
        removed_reg   <= removed_next;
        sent_reg      <= sent_next;
        hold_kind_reg <= hold_kind_next;
        hold_seq_reg  <= hold_seq_next;
        out_kind_reg  <= out_kind_next;
        out_seq_reg   <= out_seq_next;
        out_last_reg  <= out_last_next;
    end

    assign m_valid = out_valid_reg;
    assign m_kind  = out_kind_reg;
    assign m_seq   = out_seq_reg;
    assign m_last  = out_last_reg;

endmodule

// File: verif/selective_repeat_send_window_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_send_window_tb: self-checking bench for the send window
// Drives ticks, acknowledgments and send rounds through the request channel.
// A behavioral window model in the bench predicts every result; results are
// compared in order, under several register settings and idling patterns.
// ----------------------------------------------------------------------------
module selective_repeat_send_window_tb;

    localparam int DEPTH   = 32;
    localparam int AGE_MAX = 65535;
    localparam logic [srsw_pkg::CMD_W-1:0] CMD_BAD = 2'd3;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [srsw_pkg::CIDX_W-1:0]   cfg_index = '0;
    logic [srsw_pkg::CDATA_W-1:0]  cfg_wdata = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [srsw_pkg::CMD_W-1:0]    s_cmd = '0;
    logic [srsw_pkg::SEQ_W-1:0]    s_ack_seq = '0;
    logic [srsw_pkg::PROT_W-1:0]   s_ack_protocol = '0;
    logic [srsw_pkg::TYPE_W-1:0]   s_ack_type = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [srsw_pkg::KIND_W-1:0]   m_kind;
    logic [srsw_pkg::SEQ_W-1:0]    m_seq;
    logic                          m_last;

    selective_repeat_send_window dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    typedef struct packed {
        logic [srsw_pkg::KIND_W-1:0] kind;
        logic [srsw_pkg::SEQ_W-1:0]  seq;
        logic                        last;
    } window_result_t;

    typedef struct {
        logic [srsw_pkg::CMD_W-1:0]  cmd;
        logic [srsw_pkg::SEQ_W-1:0]  seq;
        logic [srsw_pkg::PROT_W-1:0] prot;
        logic [srsw_pkg::TYPE_W-1:0] typ;
        int                          fixed_kind;   // -1 when only the model decides
        logic [srsw_pkg::SEQ_W-1:0]  fixed_seq;
    } request_row_t;

    // Model copy of the registers and the slot table.
    srsw_pkg::cfg_t              cfg;
    logic [srsw_pkg::SEQ_W-1:0]  model_nseq;
    int                          in_flight;
    bit                          occupied [DEPTH];
    logic [srsw_pkg::SEQ_W-1:0]  slot_seq [DEPTH];
    int unsigned                 slot_age [DEPTH];

    window_result_t     pending_results[$];
    int                 errors = 0;
    int                 results_seen = 0;
    int                 requests_sent = 0;
    int                 sender_idle_pct = 0;
    int                 receiver_stall_pct = 0;

    function automatic void model_reset();
        cfg.packet_total  = 0;
        cfg.window_limit  = 32;
        cfg.send_batch    = 32;
        cfg.rto_ticks     = 100;
        cfg.proto_ident   = 0;
        cfg.ack_type_code = 0;
        model_nseq = 0;
        in_flight  = 0;
        foreach (occupied[i]) occupied[i] = 1'b0;
    endfunction

    function automatic void push_result(srsw_pkg::kind_t k, logic [srsw_pkg::SEQ_W-1:0] s);
        window_result_t r;
        r.kind = k;
        r.seq  = s;
        r.last = 1'b0;
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Predicts the results of one request and appends them to the queue.
    function automatic void predict_window(logic [srsw_pkg::CMD_W-1:0] cmd,
                                           logic [srsw_pkg::SEQ_W-1:0] aseq,
                                           logic [srsw_pkg::PROT_W-1:0] aprot,
                                           logic [srsw_pkg::TYPE_W-1:0] atype);
        int before_n;
        int sent;
        int cap;
        int free_slot;
        bit removed;
        before_n = pending_results.size();
        if (cmd == srsw_pkg::CMD_TICK) begin
            for (int i = 0; i < DEPTH; i++)
                if (occupied[i] && slot_age[i] < AGE_MAX) slot_age[i]++;
            push_result(srsw_pkg::KIND_IDLE, '0);
        end else if (cmd == srsw_pkg::CMD_ACK) begin
            removed = 1'b0;
            if (aprot == cfg.proto_ident && atype == cfg.ack_type_code) begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (!removed && occupied[i] && slot_seq[i] == aseq) begin
                        occupied[i] = 1'b0;
                        in_flight--;
                        removed = 1'b1;
                    end
                end
            end
            push_result(removed ? srsw_pkg::KIND_ACKED : srsw_pkg::KIND_IGNORED, aseq);
        end else if (cmd == srsw_pkg::CMD_ROUND) begin
            cap  = (cfg.send_batch < DEPTH) ? cfg.send_batch : DEPTH;
            sent = 0;
            while (model_nseq < cfg.packet_total && sent < cap &&
                   in_flight < cfg.window_limit && in_flight < DEPTH) begin
                free_slot = -1;
                for (int i = DEPTH - 1; i >= 0; i--)
                    if (!occupied[i]) free_slot = i;
                if (free_slot < 0) break;
                occupied[free_slot] = 1'b1;
                slot_seq[free_slot] = model_nseq;
                slot_age[free_slot] = 0;
                in_flight++;
                push_result(srsw_pkg::KIND_NEW, model_nseq);
                model_nseq++;
                sent++;
            end
            for (int i = 0; i < DEPTH; i++) begin
                if (occupied[i] && slot_age[i] >= cfg.rto_ticks) begin
                    slot_age[i] = 0;
                    push_result(srsw_pkg::KIND_RETX, slot_seq[i]);
                end
            end
            if (pending_results.size() == before_n) begin
                if (model_nseq >= cfg.packet_total && in_flight == 0)
                    push_result(srsw_pkg::KIND_DONE, model_nseq);
                else
                    push_result(srsw_pkg::KIND_IDLE, '0);
            end
        end else begin
            push_result(srsw_pkg::KIND_IDLE, '0);
        end
        pending_results[pending_results.size() - 1].last = 1'b1;
    endfunction

    // Result checker: compares each accepted result with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result kind=%0d seq=%0d", m_kind, m_seq);
                errors++;
            end else begin
                window_result_t want;
                want = pending_results.pop_front();
                if (m_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_kind);
                    errors++;
                end
                if (m_seq !== want.seq) begin
                    $error("seq: expected %0d, got %0d", want.seq, m_seq);
                    errors++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_last);
                    errors++;
                end
            end
        end
    end

    // Receiver back-pressure, changed on the falling edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic write_reg(logic [srsw_pkg::CIDX_W-1:0] idx,
                             logic [srsw_pkg::CDATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            srsw_pkg::REG_TOTAL:    cfg.packet_total  = val;
            srsw_pkg::REG_WINDOW:   cfg.window_limit  = val[srsw_pkg::LIM_W-1:0];
            srsw_pkg::REG_BATCH:    cfg.send_batch    = val[srsw_pkg::LIM_W-1:0];
            srsw_pkg::REG_RTO:      cfg.rto_ticks     = val[srsw_pkg::RTO_W-1:0];
            srsw_pkg::REG_PROTOCOL: cfg.proto_ident   = val;
            srsw_pkg::REG_ACK_TYPE: cfg.ack_type_code = val[srsw_pkg::TYPE_W-1:0];
            default: ;
        endcase
    endtask

    // Presents one request, predicting at the moment it is accepted. It waits
    // for a falling edge after the caller's last action, so the drop of the
    // previous valid and the raise of the next never share a time step.
    task automatic send_request(logic [srsw_pkg::CMD_W-1:0] cmd,
                                logic [srsw_pkg::SEQ_W-1:0] aseq,
                                logic [srsw_pkg::PROT_W-1:0] aprot,
                                logic [srsw_pkg::TYPE_W-1:0] atype);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) @(negedge aclk);
        s_valid        <= 1'b1;
        s_cmd          <= cmd;
        s_ack_seq      <= aseq;
        s_ack_protocol <= aprot;
        s_ack_type     <= atype;
        do @(posedge aclk); while (!s_ready);
        predict_window(cmd, aseq, aprot, atype);
        requests_sent++;
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Waits for every predicted result, then lets the walk settle.
    task automatic drain_results();
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (2 * DEPTH + 8) @(negedge aclk);
    endtask

    function automatic logic [srsw_pkg::SEQ_W-1:0] pick_ack_seq();
        // Mostly an outstanding sequence number, sometimes a stray one.
        if ($urandom_range(9) < 7 && in_flight > 0) begin
            for (int t = 0; t < 64; t++) begin
                int i;
                i = $urandom_range(DEPTH - 1);
                if (occupied[i]) return slot_seq[i];
            end
        end
        return ($urandom_range(1)) ? $urandom() : $urandom_range(40);
    endfunction

    task automatic random_phase(int count, int idle_pct, int stall_pct);
        int c;
        logic [srsw_pkg::PROT_W-1:0] p;
        logic [srsw_pkg::TYPE_W-1:0] t;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            c = $urandom_range(99);
            if (c < 30) begin
                send_request(srsw_pkg::CMD_TICK, $urandom(), $urandom(),
                             srsw_pkg::TYPE_W'($urandom()));
            end else if (c < 60) begin
                p = cfg.proto_ident;
                t = cfg.ack_type_code;
                // About a tenth of acknowledgments carry a wrong protocol, about a tenth a wrong type.
                if ($urandom_range(9) == 0) p = $urandom();
                if ($urandom_range(9) == 0) t = srsw_pkg::TYPE_W'($urandom());
                send_request(srsw_pkg::CMD_ACK, pick_ack_seq(), p, t);
            end else if (c < 97) begin
                send_request(srsw_pkg::CMD_ROUND, $urandom(), $urandom(),
                             srsw_pkg::TYPE_W'($urandom()));
            end else begin
                send_request(CMD_BAD, $urandom(), $urandom(),
                             srsw_pkg::TYPE_W'($urandom()));
            end
        end
        drain_results();
    endtask

    request_row_t directed_rows[$];

    function automatic void add_row(logic [srsw_pkg::CMD_W-1:0] cmd,
                                    logic [srsw_pkg::SEQ_W-1:0] aseq,
                                    logic [srsw_pkg::PROT_W-1:0] aprot,
                                    logic [srsw_pkg::TYPE_W-1:0] atype,
                                    int fk, logic [srsw_pkg::SEQ_W-1:0] fs);
        request_row_t r;
        r.cmd = cmd; r.seq = aseq; r.prot = aprot; r.typ = atype;
        r.fixed_kind = fk; r.fixed_seq = fs;
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    // Walks the table. Rows with a typed-in answer hold the prediction to it;
    // the checker then holds the block to the prediction.
    task automatic run_rows();
        window_result_t got;
        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].cmd, directed_rows[i].seq,
                         directed_rows[i].prot, directed_rows[i].typ);
            if (directed_rows[i].fixed_kind >= 0) begin
                got = pending_results[pending_results.size() - 1];
                if (int'(got.kind) != directed_rows[i].fixed_kind) begin
                    $error("kind: expected %0d, got %0d",
                           directed_rows[i].fixed_kind, got.kind);
                    errors++;
                end
                if (got.seq !== directed_rows[i].fixed_seq) begin
                    $error("seq: expected %0d, got %0d",
                           directed_rows[i].fixed_seq, got.seq);
                    errors++;
                end
            end
        end
        drain_results();
        directed_rows.delete();
    endtask

    initial begin
        model_reset();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Right after reset nothing is to be sent: a round reports completion
        // at sequence zero, and a tick or an unknown command answers idle.
        add_row(srsw_pkg::CMD_ROUND, '0, '0, '0, srsw_pkg::KIND_DONE, '0);
        add_row(srsw_pkg::CMD_TICK, '1, '1, '1, srsw_pkg::KIND_IDLE, '0);
        add_row(CMD_BAD, '1, '1, '1, srsw_pkg::KIND_IDLE, '0);
        add_row(srsw_pkg::CMD_ACK, 32'hFFFF_FFFF, '0, '0, srsw_pkg::KIND_IGNORED,
                32'hFFFF_FFFF);
        run_rows();

        // Full window with a zero timeout: every entry goes out twice, then
        // acknowledgments with a wrong protocol, a wrong type and a good header.
        write_reg(srsw_pkg::REG_TOTAL, 40);
        write_reg(srsw_pkg::REG_RTO, 0);
        write_reg(srsw_pkg::REG_PROTOCOL, 32'hFFFF_FFFF);
        write_reg(srsw_pkg::REG_ACK_TYPE, 8'hFF);
        add_row(srsw_pkg::CMD_ROUND, '0, '0, '0, -1, '0);
        add_row(srsw_pkg::CMD_ACK, 5, 32'hFFFF_FFFE, 8'hFF, srsw_pkg::KIND_IGNORED, 5);
        add_row(srsw_pkg::CMD_ACK, 5, 32'hFFFF_FFFF, 8'h7F, srsw_pkg::KIND_IGNORED, 5);
        add_row(srsw_pkg::CMD_ACK, 5, 32'hFFFF_FFFF, 8'hFF, srsw_pkg::KIND_ACKED, 5);
        add_row(srsw_pkg::CMD_ACK, 5, 32'hFFFF_FFFF, 8'hFF, srsw_pkg::KIND_IGNORED, 5);
        add_row(srsw_pkg::CMD_ACK, 0, 32'hFFFF_FFFF, 8'hFF, srsw_pkg::KIND_ACKED, 0);
        add_row(srsw_pkg::CMD_ROUND, '0, '0, '0, -1, '0);
        run_rows();

        // Zero window and zero batch allow no new sends; a window above the
        // table depth is bounded by the free slots; batch of one.
        write_reg(srsw_pkg::REG_RTO, 16'hFFFF);
        write_reg(srsw_pkg::REG_WINDOW, 0);
        send_request(srsw_pkg::CMD_ROUND, '0, '0, '0);
        drain_results();
        write_reg(srsw_pkg::REG_WINDOW, 63);
        write_reg(srsw_pkg::REG_BATCH, 0);
        send_request(srsw_pkg::CMD_ROUND, '0, '0, '0);
        drain_results();
        write_reg(srsw_pkg::REG_BATCH, 1);
        send_request(srsw_pkg::CMD_ROUND, '0, '0, '0);
        drain_results();
        write_reg(srsw_pkg::REG_BATCH, 63);
        send_request(srsw_pkg::CMD_ROUND, '0, '0, '0);
        drain_results();
        // A short timeout makes ticks lead to retransmits.
        write_reg(srsw_pkg::REG_RTO, 1);
        send_request(srsw_pkg::CMD_TICK, '0, '0, '0);
        send_request(srsw_pkg::CMD_ROUND, '0, '0, '0);
        drain_results();

        // Random phases under different registers and idling patterns.
        write_reg(srsw_pkg::REG_TOTAL, 32'hFFFF_FFFF);
        write_reg(srsw_pkg::REG_WINDOW, 8);
        write_reg(srsw_pkg::REG_BATCH, 3);
        write_reg(srsw_pkg::REG_RTO, 3);
        write_reg(srsw_pkg::REG_PROTOCOL, $urandom());
        write_reg(srsw_pkg::REG_ACK_TYPE, $urandom_range(255));
        random_phase(25, 0, 0);

        write_reg(srsw_pkg::REG_WINDOW, 32);
        write_reg(srsw_pkg::REG_BATCH, 32);
        write_reg(srsw_pkg::REG_RTO, 2);
        random_phase(25, 46, 0);

        write_reg(srsw_pkg::REG_TOTAL, model_nseq + 20);
        write_reg(srsw_pkg::REG_WINDOW, 1);
        write_reg(srsw_pkg::REG_BATCH, 1);
        write_reg(srsw_pkg::REG_RTO, 1);
        random_phase(25, 0, 46);

        write_reg(srsw_pkg::REG_WINDOW, 16);
        write_reg(srsw_pkg::REG_BATCH, 5);
        write_reg(srsw_pkg::REG_RTO, 4);
        random_phase(25, 37, 37);

        // Let the window empty so the transfer can be seen to complete.
        write_reg(srsw_pkg::REG_TOTAL, model_nseq);
        write_reg(srsw_pkg::REG_PROTOCOL, 0);
        write_reg(srsw_pkg::REG_ACK_TYPE, 0);
        sender_idle_pct = 0;
        for (int i = 0; i < DEPTH; i++)
            if (occupied[i]) send_request(srsw_pkg::CMD_ACK, slot_seq[i], '0, '0);
        send_request(srsw_pkg::CMD_ROUND, '0, '0, '0);
        drain_results();

        $display("Checked %0d results from %0d requests over several register settings,",
                 results_seen, requests_sent);
        $display("covering acknowledgments, timeouts, window limits and back-pressure.");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
